FILE: hw/rtl/cotangent_edge_weight_defines.svh
// Assertion macros for the cotangent edge weight block.
// Used by the top level only; no other dependencies.
`ifndef COTANGENT_EDGE_WEIGHT_DEFINES_SVH
`define COTANGENT_EDGE_WEIGHT_DEFINES_SVH

// same-cycle implication, disabled in reset
`define CEW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication, disabled in reset
`define CEW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");

`endif

FILE: hw/rtl/cew_pkg.sv
// Package for the cotangent edge weight block: widths, payload types, latency.
// No dependencies.
package cew_pkg;

  localparam int CoordW    = 24;
  localparam int DiffW     = CoordW + 1;
  localparam int ProdW     = 2 * DiffW;
  localparam int CrossW    = ProdW + 1;
  localparam int CrossMagW = ProdW;
  localparam int HalfW     = CrossMagW / 2;
  localparam int SqW       = 2 * CrossMagW;
  localparam int C2W       = SqW + 2;
  localparam int RootW     = C2W / 2;
  localparam int DotW      = ProdW + 2;
  localparam int DotMagW   = DotW - 1;
  localparam int HalfShift = 15;
  localparam int NumW      = DotMagW + HalfShift;
  localparam int QuotW     = 40;
  localparam int TermW     = QuotW + 2;
  localparam int WeightW   = 32;
  // front stages, root stages, divide setup, quotient stages
  localparam int ApexLat   = 5 + RootW + 1 + QuotW;

  typedef struct packed {
    logic signed [CoordW-1:0] x;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [CoordW-1:0] end_a_x;
    logic signed [CoordW-1:0] end_a_y;
    logic signed [CoordW-1:0] end_a_z;
    logic signed [CoordW-1:0] end_b_x;
    logic signed [CoordW-1:0] end_b_y;
    logic signed [CoordW-1:0] end_b_z;
    logic signed [CoordW-1:0] apex_one_x;
    logic signed [CoordW-1:0] apex_one_y;
    logic signed [CoordW-1:0] apex_one_z;
    logic signed [CoordW-1:0] apex_two_x;
    logic signed [CoordW-1:0] apex_two_y;
    logic signed [CoordW-1:0] apex_two_z;
  } in_t;

  typedef struct packed {
    logic signed [WeightW-1:0] edge_weight;
    logic                      degenerate;
  } out_t;

endpackage

FILE: hw/rtl/cotangent_edge_weight.sv
// Channel   Dir  Handshake                  Payload
// in        in   in_valid_i / in_stall_o    in_data_i  (in_t, one mesh edge)
// out       out  out_valid_o / out_stall_i  out_data_o (out_t, weight + flag)
//
// One edge per cycle while the output is not stalled; the pipeline depth comes mostly from
// the one-bit-per-stage root and quotient pipelines inside each apex unit.
// Reset clears only the valid bits; the datapath registers are not reset.
// A stalled output freezes the whole pipeline, so nothing is dropped or repeated.
// Depends on cew_pkg, cew_apex and cotangent_edge_weight_defines.svh.
`include "cotangent_edge_weight_defines.svh"

module cotangent_edge_weight import cew_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  logic                    adv;
  logic [ApexLat-1:0]      vld_q;
  logic                    out_valid_q;
  out_t                    out_q;
  vec_t                    a_v, b_v, p1_v, p2_v;
  logic signed [TermW-1:0] t1, t2;
  logic                    dg1, dg2;
  logic signed [TermW:0]   sum;
  logic signed [TermW+1:0] w_full;
  logic signed [WeightW-1:0] w_sat;

  localparam logic signed [TermW+1:0] WMax =
    {{(TermW+3-WeightW){1'b0}}, {(WeightW-1){1'b1}}};
  localparam logic signed [TermW+1:0] WMin =
    {{(TermW+3-WeightW){1'b1}}, {(WeightW-1){1'b0}}};

  assign adv        = !out_valid_q || !out_stall_i;
  assign in_stall_o = !adv;

  assign a_v  = '{x: in_data_i.end_a_x, y: in_data_i.end_a_y, z: in_data_i.end_a_z};
  assign b_v  = '{x: in_data_i.end_b_x, y: in_data_i.end_b_y, z: in_data_i.end_b_z};
  assign p1_v = '{x: in_data_i.apex_one_x, y: in_data_i.apex_one_y,
                  z: in_data_i.apex_one_z};
  assign p2_v = '{x: in_data_i.apex_two_x, y: in_data_i.apex_two_y,
                  z: in_data_i.apex_two_z};

  cew_apex u_apex_one (
    .clk_i   (clk_i),
    .en_i    (adv),
    .a_i     (a_v),
    .b_i     (b_v),
    .p_i     (p1_v),
    .term_o  (t1),
    .degen_o (dg1)
  );

  cew_apex u_apex_two (
    .clk_i   (clk_i),
    .en_i    (adv),
    .a_i     (a_v),
    .b_i     (b_v),
    .p_i     (p2_v),
    .term_o  (t2),
    .degen_o (dg2)
  );

  always_comb begin
    sum    = (TermW+1)'(t1) + (TermW+1)'(t2);
    w_full = -(TermW+2)'(sum);
    if (w_full > WMax) begin
      w_sat = WeightW'(WMax);
    end else if (w_full < WMin) begin
      w_sat = WeightW'(WMin);
    end else begin
      w_sat = WeightW'(w_full);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[ApexLat-2:0], in_valid_i};
      out_valid_q <= vld_q[ApexLat-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.degenerate  <= dg1 || dg2;
      out_q.edge_weight <= (dg1 || dg2) ? '0 : w_sat;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CEW_ASSERT_NOW(a_empty_no_stall, clk_i, rst_ni, !out_valid_q, !in_stall_o)
  `CEW_ASSERT_NOW(a_degen_zero, clk_i, rst_ni, out_valid_q && out_q.degenerate,
                  out_q.edge_weight == '0)
  `CEW_ASSERT_NEXT(a_accept_tracked, clk_i, rst_ni, in_valid_i && !in_stall_o, vld_q[0])

endmodule

FILE: hw/rtl/cew_apex.sv
// One triangle's cotangent term: cross/dot products, pipelined square root
// and restoring divide. Depends on cew_pkg.
module cew_apex import cew_pkg::*; (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  vec_t                    a_i,
  input  vec_t                    b_i,
  input  vec_t                    p_i,
  output logic signed [TermW-1:0] term_o,
  output logic                    degen_o
);

  typedef struct packed {
    logic [NumW-1:0] num;
    logic            neg;
    logic            degen;
  } side_t;

  typedef struct packed {
    logic [RootW-1:0] s;
    logic [QuotW-1:0] num_lo;
    logic             neg;
    logic             degen;
    logic             ovf;
  } div_side_t;

  // stage 1: edge vectors from the apex
  logic signed [DiffW-1:0] u_q [3];
  logic signed [DiffW-1:0] v_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      u_q[0] <= DiffW'(a_i.x) - DiffW'(p_i.x);
      u_q[1] <= DiffW'(a_i.y) - DiffW'(p_i.y);
      u_q[2] <= DiffW'(a_i.z) - DiffW'(p_i.z);
      v_q[0] <= DiffW'(b_i.x) - DiffW'(p_i.x);
      v_q[1] <= DiffW'(b_i.y) - DiffW'(p_i.y);
      v_q[2] <= DiffW'(b_i.z) - DiffW'(p_i.z);
    end
  end

  // stage 2: the nine products
  logic signed [ProdW-1:0] xp_q [3];
  logic signed [ProdW-1:0] xn_q [3];
  logic signed [ProdW-1:0] dp_q [3];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      xp_q[0] <= u_q[1] * v_q[2];
      xn_q[0] <= u_q[2] * v_q[1];
      xp_q[1] <= u_q[2] * v_q[0];
      xn_q[1] <= u_q[0] * v_q[2];
      xp_q[2] <= u_q[0] * v_q[1];
      xn_q[2] <= u_q[1] * v_q[0];
      for (int i = 0; i < 3; i++) begin
        dp_q[i] <= u_q[i] * v_q[i];
      end
    end
  end

  // stage 3: cross components and dot product, as magnitudes
  logic signed [CrossW-1:0] cross_d [3];
  logic signed [DotW-1:0]   dot_d;
  logic signed [DotW-1:0]   dot_abs;
  logic [CrossMagW-1:0]     cmag_q [3];
  logic [DotMagW-1:0]       dmag_q;
  logic                     dneg_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cross_d[i] = CrossW'(xp_q[i]) - CrossW'(xn_q[i]);
    end
    dot_d   = DotW'(dp_q[0]) + DotW'(dp_q[1]) + DotW'(dp_q[2]);
    dot_abs = dot_d[DotW-1] ? -dot_d : dot_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        cmag_q[i] <= cross_d[i][CrossW-1] ? CrossMagW'(-cross_d[i])
                                          : CrossMagW'(cross_d[i]);
      end
      dmag_q <= dot_abs[DotMagW-1:0];
      dneg_q <= dot_d[DotW-1];
    end
  end

  // stage 4: partial products of the squares
  logic [2*HalfW-1:0] hh_q [3];
  logic [2*HalfW-1:0] hl_q [3];
  logic [2*HalfW-1:0] ll_q [3];
  side_t              s4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        hh_q[i] <= cmag_q[i][CrossMagW-1:HalfW] * cmag_q[i][CrossMagW-1:HalfW];
        hl_q[i] <= cmag_q[i][CrossMagW-1:HalfW] * cmag_q[i][HalfW-1:0];
        ll_q[i] <= cmag_q[i][HalfW-1:0] * cmag_q[i][HalfW-1:0];
      end
      s4_q.num   <= {dmag_q, HalfShift'(0)};
      s4_q.neg   <= dneg_q;
      // zero area exactly when all cross components vanish
      s4_q.degen <= (cmag_q[0] == '0) && (cmag_q[1] == '0) && (cmag_q[2] == '0);
    end
  end

  // stage 5: squared twice-area, seeds the root pipeline
  logic [C2W-1:0]   c2_d;
  logic [C2W-1:0]   rem_q  [RootW+1];
  logic [RootW-1:0] root_q [RootW+1];
  side_t            sd_q   [RootW+1];

  always_comb begin
    c2_d = '0;
    for (int i = 0; i < 3; i++) begin
      c2_d = c2_d + (C2W'(hh_q[i]) << (2 * HalfW)) + (C2W'(hl_q[i]) << (HalfW + 1))
                  + C2W'(ll_q[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= c2_d;
      root_q[0] <= '0;
      sd_q[0]   <= s4_q;
    end
  end

  // one root bit per stage; rem holds c2 - root^2
  for (genvar i = 0; i < RootW; i++) begin : g_root
    localparam int K = RootW - 1 - i;
    logic [C2W-1:0] trial;
    assign trial = (C2W'(root_q[i]) << (K + 1)) | (C2W'(1) << (2 * K));

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sd_q[i+1] <= sd_q[i];
        if (rem_q[i] >= trial) begin
          rem_q[i+1]  <= rem_q[i] - trial;
          root_q[i+1] <= root_q[i] | (RootW'(1) << K);
        end else begin
          rem_q[i+1]  <= rem_q[i];
          root_q[i+1] <= root_q[i];
        end
      end
    end
  end

  // divide setup: quotient at or above 2^QuotW saturates
  logic [RootW:0]   drem_q [QuotW+1];
  logic [QuotW-1:0] quo_q  [QuotW+1];
  div_side_t        dv_q   [QuotW+1];
  logic [NumW-QuotW-1:0] num_hi;

  assign num_hi = sd_q[RootW].num[NumW-1:QuotW];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      drem_q[0]       <= (RootW+1)'(num_hi);
      quo_q[0]        <= '0;
      dv_q[0].s       <= root_q[RootW];
      dv_q[0].num_lo  <= sd_q[RootW].num[QuotW-1:0];
      dv_q[0].neg     <= sd_q[RootW].neg;
      dv_q[0].degen   <= sd_q[RootW].degen;
      dv_q[0].ovf     <= (RootW+1)'(num_hi) >= (RootW+1)'(root_q[RootW]);
    end
  end

  for (genvar j = 0; j < QuotW; j++) begin : g_div
    localparam int B = QuotW - 1 - j;
    logic [RootW:0] shifted;
    assign shifted = {drem_q[j][RootW-1:0], dv_q[j].num_lo[B]};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dv_q[j+1] <= dv_q[j];
        if (shifted >= {1'b0, dv_q[j].s}) begin
          drem_q[j+1] <= shifted - {1'b0, dv_q[j].s};
          quo_q[j+1]  <= quo_q[j] | (QuotW'(1) << B);
        end else begin
          drem_q[j+1] <= shifted;
          quo_q[j+1]  <= quo_q[j];
        end
      end
    end
  end

  logic [QuotW:0] mag;
  assign mag     = dv_q[QuotW].ovf ? ((QuotW+1)'(1) << QuotW) : {1'b0, quo_q[QuotW]};
  assign term_o  = dv_q[QuotW].neg ? -TermW'(mag) : TermW'(mag);
  assign degen_o = dv_q[QuotW].degen;

endmodule

FILE: tb/cotangent_edge_weight_tb.sv
// Self-checking testbench for cotangent_edge_weight: directed and random mesh edges,
// bit-exact weight prediction with wide integer arithmetic, random idling on both sides.
// Depends on cew_pkg and the cotangent_edge_weight RTL.
`timescale 1ns / 1ps

module cotangent_edge_weight_tb;
  import cew_pkg::*;

  typedef logic signed [159:0] wide_t;
  typedef logic [159:0] uwide_t;

  localparam int Latency   = ApexLat + 1;
  localparam int HoldLen   = 3 * Latency;
  localparam int CycleCap  = 300000;
  localparam int RandItems = 140;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_stall_o;
  in_t  in_data_i;
  logic out_valid_o;
  logic out_stall_i;
  out_t out_data_o;

  in_t  edge_q[$];
  out_t weight_q[$];
  int   send_idle_pct;
  int   recv_idle_pct;
  bit   hold_req;
  bit   hold_done;
  int   hold_left;
  int   err_cnt;
  int   edges_in;
  int   weights_out;
  int   degen_cnt;
  int   sat_cnt;
  int   cycle_cnt;

  cotangent_edge_weight i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // cotangent at apex p times 2^15, truncated toward zero, magnitude clamped to 2^40
  function automatic logic signed [63:0] apex_cot(input vec_t a, input vec_t b, input vec_t p,
                                                   inout bit flat);
    wide_t  ux, uy, uz, vx, vy, vz, cx, cy, cz, c2, dot;
    uwide_t mag, root, cand, quot;
    wide_t  pa_x, pa_y, pa_z;
    pa_x = p.x; pa_y = p.y; pa_z = p.z;
    ux = a.x; uy = a.y; uz = a.z;
    vx = b.x; vy = b.y; vz = b.z;
    ux = ux - pa_x; uy = uy - pa_y; uz = uz - pa_z;
    vx = vx - pa_x; vy = vy - pa_y; vz = vz - pa_z;
    cx = uy * vz - uz * vy;
    cy = uz * vx - ux * vz;
    cz = ux * vy - uy * vx;
    c2 = cx * cx + cy * cy + cz * cz;
    if (c2 == 0) begin
      flat = 1'b1;
      return 64'sd0;
    end
    dot  = ux * vx + uy * vy + uz * vz;
    mag  = (dot < 0) ? uwide_t'(-dot) : uwide_t'(dot);
    root = '0;
    for (int k = 79; k >= 0; k--) begin
      cand = root | (uwide_t'(1) << k);
      if (cand * cand <= uwide_t'(c2)) root = cand;
    end
    quot = (mag << HalfShift) / root;
    if (quot > (uwide_t'(1) << QuotW)) quot = uwide_t'(1) << QuotW;
    return (dot < 0) ? -$signed(64'(quot)) : $signed(64'(quot));
  endfunction

  function automatic out_t edge_weight_of(input in_t e);
    vec_t a, b, p1, p2;
    logic signed [63:0] t1, t2, w;
    bit   flat;
    out_t r;
    a  = '{e.end_a_x, e.end_a_y, e.end_a_z};
    b  = '{e.end_b_x, e.end_b_y, e.end_b_z};
    p1 = '{e.apex_one_x, e.apex_one_y, e.apex_one_z};
    p2 = '{e.apex_two_x, e.apex_two_y, e.apex_two_z};
    flat = 1'b0;
    t1 = apex_cot(a, b, p1, flat);
    t2 = apex_cot(a, b, p2, flat);
    if (flat) begin
      r.edge_weight = '0;
      r.degenerate  = 1'b1;
      return r;
    end
    w = -(t1 + t2);
    if (w > 64'sd2147483647) w = 64'sd2147483647;
    if (w < -64'sd2147483648) w = -64'sd2147483648;
    r.edge_weight = w[31:0];
    r.degenerate  = 1'b0;
    return r;
  endfunction

  function automatic logic signed [CoordW-1:0] near(input int base, input int span);
    return CoordW'(base + $signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic in_t make_edge(input int ax, ay, az, bx, by, bz,
                                    p1x, p1y, p1z, p2x, p2y, p2z);
    in_t e;
    e = '{CoordW'(ax), CoordW'(ay), CoordW'(az), CoordW'(bx), CoordW'(by), CoordW'(bz),
          CoordW'(p1x), CoordW'(p1y), CoordW'(p1z), CoordW'(p2x), CoordW'(p2y), CoordW'(p2z)};
    return e;
  endfunction

  function automatic in_t random_edge();
    in_t e;
    int  mode, c, span;
    mode = $urandom_range(99);
    c    = $signed($urandom_range(2000000)) - 1000000;
    span = 1 << $urandom_range(19, 4);
    e = make_edge(near(c, span), near(c, span), near(c, span),
                  near(c, span), near(c, span), near(c, span),
                  near(c, span), near(c, span), near(c, span),
                  near(c, span), near(c, span), near(c, span));
    if (mode >= 60 && mode < 75) begin
      e = in_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom(),
                 $urandom(), $urandom(), $urandom()});
    end else if (mode >= 75 && mode < 87) begin
      // apex almost on the edge line: huge cotangent, saturation
      e.apex_one_x = (e.end_a_x + e.end_b_x) >>> 1;
      e.apex_one_y = (e.end_a_y + e.end_b_y) >>> 1;
      e.apex_one_z = ((e.end_a_z + e.end_b_z) >>> 1) + near(0, 2);
    end else if (mode >= 87 && mode < 94) begin
      // apex on an end vertex: zero area
      e.apex_two_x = e.end_b_x;
      e.apex_two_y = e.end_b_y;
      e.apex_two_z = e.end_b_z;
    end
    return e;
  endfunction

  task automatic queue_edge(input in_t e);
    edge_q.insert(edge_q.size(), e);
  endtask

  // driver
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        weight_q.insert(weight_q.size(), edge_weight_of(in_data_i));
        edges_in <= edges_in + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (edge_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid_i <= 1'b1;
          in_data_i  <= edge_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // receiver stall, with one long hold-off to fill the pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      hold_left   <= 0;
      hold_done   <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_done   <= 1'b1;
      hold_left   <= HoldLen;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (weight_q.size() == 0) begin
        $display("%0t: unexpected transaction, actual weight %0d degenerate %0b",
                 $time, out_data_o.edge_weight, out_data_o.degenerate);
        err_cnt <= err_cnt + 1;
      end else begin
        out_t exp_w;
        exp_w = weight_q.pop_front();
        weights_out <= weights_out + 1;
        if (exp_w.degenerate) degen_cnt <= degen_cnt + 1;
        if (exp_w.edge_weight == 32'sh7fffffff || exp_w.edge_weight == 32'sh80000000)
          sat_cnt <= sat_cnt + 1;
        if (out_data_o.edge_weight !== exp_w.edge_weight) begin
          $display("%0t: edge_weight mismatch, expected %0d actual %0d", $time,
                   exp_w.edge_weight, out_data_o.edge_weight);
          err_cnt <= err_cnt + 1;
        end
        if (out_data_o.degenerate !== exp_w.degenerate) begin
          $display("%0t: degenerate mismatch, expected %0b actual %0b", $time,
                   exp_w.degenerate, out_data_o.degenerate);
          err_cnt <= err_cnt + 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleCap) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic drain();
    while (edge_q.size() > 0 || in_valid_i || weight_q.size() > 0) @(posedge clk_i);
  endtask

  initial begin
    int one = 1 << 16;
    int mx  = 8388607;
    int mn  = -8388608;
    err_cnt = 0; edges_in = 0; weights_out = 0; degen_cnt = 0; sat_cnt = 0;
    cycle_cnt = 0; hold_req = 1'b0;
    send_idle_pct = 9;
    recv_idle_pct = 86;
    rst_ni = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: all zero, right angles, obtuse, collinear, extremes, near flat
    queue_edge(make_edge(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    queue_edge(make_edge(0, 0, 0, one, 0, 0, 0, one, 0, one, one, 0));
    queue_edge(make_edge(0, 0, 0, one, 0, 0, one/2, one/4, 0, one/2, -one/4, 0));
    queue_edge(make_edge(0, 0, 0, 4*one, 0, 0, 2*one, 3*one, 0, 2*one, 0, 5*one));
    queue_edge(make_edge(0, 0, 0, one, 0, 0, 2*one, 0, 0, 0, one, 0));
    queue_edge(make_edge(0, 0, 0, 0, 0, 0, one, 0, 0, 0, one, 0));
    queue_edge(make_edge(mx, mx, mx, mn, mn, mn, mx, mn, mx, mn, mx, mn));
    queue_edge(make_edge(mn, mn, mn, mx, mx, mx, mn, mx, mx, mx, mn, mn));
    queue_edge(make_edge(mn, 0, 0, mx, 0, 0, 0, mx, 0, 0, mn, 0));
    queue_edge(make_edge(mn, mn, 0, mx, mn, 0, 0, mx, 0, 0, mx, mx));
    queue_edge(make_edge(0, 0, 0, one, 0, 0, one/2, 0, 1, one/2, 1, 0));
    queue_edge(make_edge(mn, 0, 0, mx, 0, 0, 0, 1, 0, 0, 0, -1));
    queue_edge(make_edge(-one, -one, -one, one, one, one, -one, one, -one,
                         one, -one, one));
    queue_edge(make_edge(mx, mx, mx, mx, mx, mn, mn, mn, mn, mx, mn, mx));
    queue_edge(make_edge(5, 7, -3, -11, 2, 9, 1, -1, 4, -6, 8, 0));
    queue_edge(make_edge(0, 0, 0, one, one, 0, 2*one, 2*one, 0, 0, 0, one));
    for (int i = 0; i < RandItems; i++) queue_edge(random_edge());
    drain();

    send_idle_pct = 86;
    recv_idle_pct = 9;
    for (int i = 0; i < RandItems; i++) queue_edge(random_edge());
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req = 1'b1;
    for (int i = 0; i < RandItems; i++) queue_edge(random_edge());
    drain();
    repeat (Latency + 20) @(posedge clk_i);

    $display("Edges sent %0d, weights checked %0d (%0d zero-area, %0d saturated).",
             edges_in, weights_out, degen_cnt, sat_cnt);
    $display("Idle mixes: sender-light, receiver-light, none, plus one long output hold.");
    if (err_cnt == 0 && weight_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/cew_pkg.sv
hw/rtl/cew_apex.sv
hw/rtl/cotangent_edge_weight.sv
tb/cotangent_edge_weight_tb.sv
